// ===== hdl/mks_pkg.sv =====
// Package with the item types, operation codes and key code table of the keypad scanner.
`default_nettype none
package mks_pkg;

  localparam int unsigned NumKeys = 16;
  localparam int unsigned NumRows = 4;
  localparam int unsigned NumCols = 4;

  typedef enum logic [1:0] {
    OP_SCAN     = 2'd0,
    OP_DEBOUNCE = 2'd1,
    OP_SAMPLE   = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] columns;
  } mks_in_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_event;
    logic       key_known;
    logic [3:0] key_value;
    logic       scanning;
  } mks_out_t;

  typedef logic [7:0] key_code_t;

  localparam key_code_t KEY_CODES [NumKeys] = '{
    8'h41, 8'h88, 8'h48, 8'h28, 8'h84, 8'h44, 8'h24, 8'h82,
    8'h42, 8'h22, 8'h18, 8'h14, 8'h12, 8'h11, 8'h81, 8'h21
  };

endpackage
`default_nettype wire

// ===== hdl/mks_decode.sv =====
// Key code lookup that maps a captured column and row code to its key number.
`default_nettype none
module mks_decode (
  input  mks_pkg::key_code_t code_i,
  output logic               known_o,
  output logic [3:0]         value_o
);
  import mks_pkg::*;

  always_comb begin
    known_o = 1'b0;
    value_o = 4'd0;
    for (int k = 0; k < NumKeys; k++) begin
      if (KEY_CODES[k] == code_i) begin
        known_o = 1'b1;
        value_o = 4'(k);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mks_core.sv =====
// Scan state and the per-item update of row drive, capture and debounce.
`default_nettype none
module mks_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  mks_pkg::mks_in_t  item_i,
  output mks_pkg::mks_out_t result_o
);
  import mks_pkg::*;

  logic [1:0] row_index_q, row_index_d;
  logic       rows_started_q, rows_started_d;
  logic       scan_enabled_q, scan_enabled_d;
  logic       debounce_armed_q, debounce_armed_d;
  logic       debounce_phase_q, debounce_phase_d;
  logic [3:0] prev_columns_q;
  logic [3:0] rising;
  logic [3:0] drive;
  logic       capture;
  logic       known;
  logic [3:0] value;

  always_comb begin
    row_index_d      = row_index_q;
    rows_started_d   = rows_started_q;
    scan_enabled_d   = scan_enabled_q;
    debounce_armed_d = debounce_armed_q;
    debounce_phase_d = debounce_phase_q;
    case (item_i.operation)
      OP_SCAN: begin
        if (scan_enabled_q) begin
          row_index_d    = row_index_q + 2'd1;
          rows_started_d = 1'b1;
        end
      end
      OP_DEBOUNCE: begin
        if (debounce_armed_q) begin
          if (debounce_phase_q) begin
            if (item_i.columns == 4'd0) begin
              scan_enabled_d   = 1'b1;
              debounce_armed_d = 1'b0;
            end
            debounce_phase_d = 1'b0;
          end else begin
            debounce_phase_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    rising  = item_i.columns & ~prev_columns_q;
    capture = scan_enabled_d && (rising != 4'd0);
    if (capture) begin
      scan_enabled_d   = 1'b0;
      debounce_armed_d = 1'b1;
    end
    drive = rows_started_d ? (4'd1 << row_index_d) : 4'd0;
  end

  mks_decode u_decode (
    .code_i  ({item_i.columns, drive}),
    .known_o (known),
    .value_o (value)
  );

  always_comb begin
    result_o.row_drive = drive;
    result_o.key_event = capture;
    result_o.key_known = capture & known;
    result_o.key_value = capture ? value : 4'd0;
    result_o.scanning  = scan_enabled_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_index_q      <= 2'd0;
      rows_started_q   <= 1'b0;
      scan_enabled_q   <= 1'b1;
      debounce_armed_q <= 1'b0;
      debounce_phase_q <= 1'b0;
      prev_columns_q   <= 4'd0;
    end else if (step_i) begin
      row_index_q      <= row_index_d;
      rows_started_q   <= rows_started_d;
      scan_enabled_q   <= scan_enabled_d;
      debounce_armed_q <= debounce_armed_d;
      debounce_phase_q <= debounce_phase_d;
      prev_columns_q   <= item_i.columns;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/matrix_keypad_scanner.sv =====
// Top level of the 4x4 key matrix scanner with input and result registers.
//
// The input channel carries one item per tick or column sample: an operation
// (scan tick, debounce tick or plain sample) and the current column levels.
// The output channel returns exactly one result item per input item, in order:
// the row drive, a key event flag, the decoded key and the scanning flag.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low.
// An accepted item waits in the input register, is processed by the scan
// logic and lands in the result register, from which the result is offered
// until the receiver takes it.
// One item is taken every cycle while results drain.
// When the receiver stalls, the result register holds and the input register
// fills; input stall then rises until the result is taken.
// Reset clears both valid flags and returns the scanner to its initial state:
// rows low, scanning on, debounce disarmed and previous columns zero.
`default_nettype none
module matrix_keypad_scanner (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mks_pkg::mks_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mks_pkg::mks_out_t out_item_o
);
  import mks_pkg::*;

  logic     in_valid_q;
  mks_in_t  in_item_q;
  logic     out_valid_q;
  mks_out_t out_item_q;
  mks_out_t result;
  logic     advance;
  logic     step;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  mks_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire
